@@ sv/aes256_pkg.sv @@
// constants, tables and round functions shared by the aes-256 block cipher unit
package aes256_pkg;

  localparam int NumRoundsDefault = 14;
  localparam int KeyWords = 8;
  localparam int KeyRegs = 4;
  localparam int CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] KEY_WORD0 = 3'd0;
  localparam logic [CfgIndexW-1:0] KEY_WORD1 = 3'd1;
  localparam logic [CfgIndexW-1:0] KEY_WORD2 = 3'd2;
  localparam logic [CfgIndexW-1:0] KEY_WORD3 = 3'd3;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] POLY_RED = 8'h1b;

  typedef logic [127:0] block_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? POLY_RED : 8'h00);
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] x);
    return xt(xt(xt(x))) ^ x;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(x) ^ x;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(xt(x)) ^ x;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(xt(x)) ^ xt(x);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // byte (row, col) sits at index 4*col + row, byte 0 in the top bits
  function automatic block_t enc_round(input block_t s, input block_t k, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    block_t r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[4*c+w] = FWD_SBOX[b[4*((c+w)%4)+w]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        b[4*c]   = xt(t[4*c])   ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        b[4*c+1] = xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3] ^ t[4*c];
        b[4*c+2] = xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3] ^ t[4*c]   ^ t[4*c+1];
        b[4*c+3] = xt(t[4*c+3]) ^ xt(t[4*c])   ^ t[4*c]   ^ t[4*c+1] ^ t[4*c+2];
      end
    end else begin
      for (int i = 0; i < 16; i++) b[i] = t[i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r ^ k;
  endfunction

  function automatic block_t dec_round(input block_t s, input block_t k, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    block_t r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[4*((c+w)%4)+w] = INV_SBOX[b[4*c+w]];
    for (int i = 0; i < 16; i++) t[i] = t[i] ^ k[127-8*i -: 8];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        b[4*c]   = mul14(t[4*c])   ^ mul11(t[4*c+1]) ^ mul13(t[4*c+2]) ^ mul9(t[4*c+3]);
        b[4*c+1] = mul14(t[4*c+1]) ^ mul11(t[4*c+2]) ^ mul13(t[4*c+3]) ^ mul9(t[4*c]);
        b[4*c+2] = mul14(t[4*c+2]) ^ mul11(t[4*c+3]) ^ mul13(t[4*c])   ^ mul9(t[4*c+1]);
        b[4*c+3] = mul14(t[4*c+3]) ^ mul11(t[4*c])   ^ mul13(t[4*c+1]) ^ mul9(t[4*c+2]);
      end
    end else begin
      for (int i = 0; i < 16; i++) b[i] = t[i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r;
  endfunction

endpackage

@@ sv/aes256_block_cipher_unit.sv @@
// aes-256 ecb cipher: key schedule sequencer and one pipeline stage per round
//
// channel   direction  handshake              payload
// config    in         wr_en                  wr_index, wr_data
// item in   in         start && !busy         command, block_high, block_low
// result    out        done (one cycle)       out_high, out_low, was_decrypt
//
// one item per cycle while busy is low; items pass st[0] and then the round stages
// after reset and after every key write the schedule is rebuilt, one key word a cycle,
// and busy stays high until the last round key word has been written
// rst is synchronous and clears the valid bits and the key registers
// the receiver cannot stall: the pipeline never holds
module aes256_block_cipher_unit
  import aes256_pkg::*;
#(
  parameter int NUM_ROUNDS = NumRoundsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [63:0]          wr_data,
  input  logic                 start,
  input  logic                 command,
  input  logic [63:0]          block_high,
  input  logic [63:0]          block_low,
  output logic                 busy,
  output logic                 done,
  output logic [63:0]          out_high,
  output logic [63:0]          out_low,
  output logic                 was_decrypt
);

  localparam int NumWords = 4 * (NUM_ROUNDS + 1);
  localparam int WordIdxW = $clog2(NumWords);
  localparam logic [WordIdxW-1:0] LastWord = WordIdxW'(NumWords - 1);
  localparam logic [WordIdxW-1:0] FirstGen = WordIdxW'(KeyWords);

  typedef enum logic [2:0] {
    KS_IDLE = 3'b001,
    KS_LOAD = 3'b010,
    KS_RUN  = 3'b100
  } ks_state_t;

  ks_state_t ks_state;
  ks_state_t ks_state_next;
  logic [63:0] key_reg [KeyRegs];
  logic [31:0] window [KeyWords];
  logic [31:0] rk_word [NumWords];
  logic [WordIdxW-1:0] wcnt;
  logic [7:0] rc;
  logic [31:0] temp;
  logic [31:0] new_word;
  logic key_write;
  block_t rkey [NUM_ROUNDS+1];
  block_t st [NUM_ROUNDS+1];
  logic vld [NUM_ROUNDS+1];
  logic dec [NUM_ROUNDS+1];
  logic accept;

  assign key_write = wr_en && (wr_index == KEY_WORD0 || wr_index == KEY_WORD1 ||
                               wr_index == KEY_WORD2 || wr_index == KEY_WORD3);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyRegs; i++) key_reg[i] <= '0;
    end else if (key_write) begin
      key_reg[wr_index[1:0]] <= wr_data;
    end
  end

  always_comb begin
    unique case (ks_state)
      KS_LOAD: ks_state_next = KS_RUN;
      KS_RUN:  ks_state_next = (wcnt == LastWord) ? KS_IDLE : KS_RUN;
      KS_IDLE: ks_state_next = KS_IDLE;
      default: ks_state_next = KS_LOAD;
    endcase
    if (key_write) ks_state_next = KS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_state <= KS_LOAD;
    end else begin
      ks_state <= ks_state_next;
    end
  end

  always_comb begin
    temp = window[KeyWords-1];
    if (wcnt[2:0] == 3'd0) begin
      temp = sub_word({temp[23:0], temp[31:24]}) ^ {rc, 24'h0};
    end else if (wcnt[2:0] == 3'd4) begin
      temp = sub_word(temp);
    end
    new_word = window[0] ^ temp;
  end

  always_ff @(posedge clk) begin
    if (ks_state == KS_LOAD) begin
      for (int i = 0; i < KeyRegs; i++) begin
        window[2*i]     <= key_reg[i][63:32];
        window[2*i+1]   <= key_reg[i][31:0];
        rk_word[2*i]    <= key_reg[i][63:32];
        rk_word[2*i+1]  <= key_reg[i][31:0];
      end
      wcnt <= FirstGen;
      rc <= RCON_FIRST;
    end else if (ks_state == KS_RUN) begin
      for (int i = 0; i < KeyWords - 1; i++) window[i] <= window[i+1];
      window[KeyWords-1] <= new_word;
      rk_word[wcnt] <= new_word;
      if (wcnt != LastWord) wcnt <= wcnt + 1'b1;
      if (wcnt[2:0] == 3'd0) rc <= xt(rc);
    end
  end

  assign busy = (ks_state != KS_IDLE);
  assign accept = start && !busy;

  for (genvar r = 0; r <= NUM_ROUNDS; r++) begin : g_rkey
    assign rkey[r] = {rk_word[4*r], rk_word[4*r+1], rk_word[4*r+2], rk_word[4*r+3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    dec[0] <= command;
    st[0] <= {block_high, block_low} ^ ((command == CMD_DECRYPT) ? rkey[NUM_ROUNDS] : rkey[0]);
  end

  for (genvar i = 1; i <= NUM_ROUNDS; i++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld[i-1];
      end
      dec[i] <= dec[i-1];
      if (dec[i-1] == CMD_DECRYPT) begin
        st[i] <= dec_round(st[i-1], rkey[NUM_ROUNDS-i], i == NUM_ROUNDS);
      end else begin
        st[i] <= enc_round(st[i-1], rkey[i], i == NUM_ROUNDS);
      end
    end
  end

  assign done = vld[NUM_ROUNDS];
  assign out_high = st[NUM_ROUNDS][127:64];
  assign out_low = st[NUM_ROUNDS][63:0];
  assign was_decrypt = dec[NUM_ROUNDS];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(NUM_ROUNDS+1) done)
    else $error("item lost in round pipeline");
  a_cmd_echo: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(NUM_ROUNDS+1) (was_decrypt == $past(command, NUM_ROUNDS+1)))
    else $error("command echo mismatch");
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    key_write |=> busy)
    else $error("key write did not start schedule rebuild");
  a_wcnt_range: assert property (@(posedge clk) disable iff (rst)
    ks_state == KS_RUN |-> (wcnt >= FirstGen && wcnt <= LastWord))
    else $error("key word counter out of range");
`endif

endmodule
